// File: rtl/core/rgb3c_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution: shared package
// Constants, register indexes and types used by the convolution modules.
// ----------------------------------------------------------------------------
package rgb3c_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int COEF_BITS_DEF = 13;

	localparam int KSIZE = 3;
	localparam int TAPS = KSIZE * KSIZE;
	localparam int CHANNELS = 3;
	localparam int PIX_BITS = 8;
	localparam int COEF_FRAC = 8;

	localparam int WIDTH_BITS = 11;
	localparam int HEIGHT_BITS = 16;
	localparam int ROW_BITS = HEIGHT_BITS + 1;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TOP = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_MID = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BOT = 3'd4;

	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 11'd1024;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;
	localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;

	typedef logic [CHANNELS*PIX_BITS-1:0] pix_t;
	typedef pix_t [KSIZE-1:0] col_t;
	typedef pix_t [TAPS-1:0] view_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic [TAPS-1:0] mask;
	} tap_ctl_t;

endpackage

// File: rtl/core/rgb3c_ctrl.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution: scan control
// Tracks the raster position, decides which items advance the frame and
// works out the border mask and the end of frame for each result.
// ----------------------------------------------------------------------------
module rgb3c_ctrl #(
	parameter int MAX_WIDTH = rgb3c_pkg::MAX_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [rgb3c_pkg::WIDTH_BITS-1:0]     cfg_width,
	input  logic [rgb3c_pkg::HEIGHT_BITS-1:0]    cfg_height,
	input  logic                                 accept,
	input  logic                                 drain,
	input  rgb3c_pkg::pix_t                      pix,
	output logic                                 tick,
	output logic [$clog2(MAX_WIDTH)-1:0]         addr,
	output rgb3c_pkg::pix_t                      pix_out,
	output rgb3c_pkg::tap_ctl_t                  ctl
);
	import rgb3c_pkg::*;

	localparam int CA = $clog2(MAX_WIDTH);
	localparam int CW = (CA + 2 > WIDTH_BITS) ? CA + 2 : WIDTH_BITS;

	logic [CA-1:0]          col_q;
	logic [ROW_BITS-1:0]    row_q;
	logic [CW-1:0]          w_raw, w_eff, c_ext, ocol;
	logic [HEIGHT_BITS-1:0] h_eff;
	logic [ROW_BITS-1:0]    hx, orow;
	logic                   complete, wrap, emit, last, row_end;
	logic [KSIZE-1:0]       row_ok, col_ok;

	always_comb begin
		w_raw = CW'(cfg_width);
		if (w_raw == '0) begin
			w_eff = CW'(1);
		end else if (w_raw > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		h_eff = (cfg_height == '0) ? HEIGHT_BITS'(1) : cfg_height;
		hx = ROW_BITS'(h_eff);
		c_ext = CW'(col_q);

		complete = row_q >= hx;
		tick = !drain || complete;
		pix_out = (!drain && !complete) ? pix : '0;
		addr = col_q;

		emit = (row_q >= ROW_BITS'(2)) || ((row_q == ROW_BITS'(1)) && (col_q != '0));
		wrap = col_q == '0;
		orow = wrap ? row_q - ROW_BITS'(2) : row_q - ROW_BITS'(1);
		ocol = wrap ? w_eff - CW'(1) : c_ext - CW'(1);

		row_ok[0] = (orow != '0) && ((orow - ROW_BITS'(1)) < hx);
		row_ok[1] = orow < hx;
		row_ok[2] = (orow + ROW_BITS'(1)) < hx;
		col_ok[0] = (ocol != '0) && ((ocol - CW'(1)) < w_eff);
		col_ok[1] = ocol < w_eff;
		col_ok[2] = (ocol + CW'(1)) < w_eff;

		last = emit && ((orow >= hx) ||
			((orow == hx - ROW_BITS'(1)) && ((ocol + CW'(1)) >= w_eff)));
		row_end = (c_ext + CW'(1)) >= w_eff;

		ctl.emit = emit;
		ctl.last = last;
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				ctl.mask[i*KSIZE+j] = row_ok[i] & col_ok[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && tick) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + CA'(1);
			end
		end
	end

endmodule

// File: rtl/core/rgb3c_line.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution: line stores and window
// Two single-port-read line memories hold the previous rows by column. Each
// item reads its column, rotates the entries and shifts the 3x3 window.
// ----------------------------------------------------------------------------
module rgb3c_line #(
	parameter int MAX_WIDTH = rgb3c_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick_vld,
	input  logic [$clog2(MAX_WIDTH)-1:0] addr,
	input  rgb3c_pkg::pix_t              pix,
	input  rgb3c_pkg::tap_ctl_t          ctl,
	output logic                         rdy,
	output logic                         view_vld,
	output rgb3c_pkg::view_t             view,
	output rgb3c_pkg::tap_ctl_t          view_ctl,
	input  logic                         view_rdy
);
	import rgb3c_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	pix_t     mem_a [MAX_WIDTH];
	pix_t     mem_b [MAX_WIDTH];
	pix_t     rd_a_q, rd_b_q, wr_a_q, wr_b_q;
	pix_t     a_cur, b_cur;

	logic     vld_s1, fwd_s1;
	logic [AW-1:0] addr_s1;
	pix_t     pix_s1;
	tap_ctl_t ctl_s1;

	col_t     win1_q, win2_q, col_new;
	view_t    view_d, view_s2;
	tap_ctl_t ctl_s2;
	logic     vld_s2;
	logic     leave_s1, can_s2;

	// An entry written at the edge of its own read is taken from the last write.
	assign a_cur = fwd_s1 ? wr_a_q : rd_a_q;
	assign b_cur = fwd_s1 ? wr_b_q : rd_b_q;
	assign col_new = {pix_s1, a_cur, b_cur};

	assign can_s2 = !vld_s2 || view_rdy;
	assign leave_s1 = vld_s1 && (!ctl_s1.emit || can_s2);
	assign rdy = !vld_s1 || leave_s1;

	always_ff @(posedge clk) begin
		if (leave_s1) begin
			mem_a[addr_s1] <= pix_s1;
		end
		if (tick_vld) begin
			rd_a_q <= mem_a[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s1) begin
			mem_b[addr_s1] <= a_cur;
		end
		if (tick_vld) begin
			rd_b_q <= mem_b[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (tick_vld) begin
			addr_s1 <= addr;
			pix_s1 <= pix;
			ctl_s1 <= ctl;
			fwd_s1 <= leave_s1 && (addr_s1 == addr);
		end
		if (leave_s1) begin
			wr_a_q <= pix_s1;
			wr_b_q <= a_cur;
		end
		if (leave_s1 && ctl_s1.emit) begin
			view_s2 <= view_d;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			win1_q <= '0;
			win2_q <= '0;
		end else begin
			if (rdy) begin
				vld_s1 <= tick_vld;
			end
			if (can_s2) begin
				vld_s2 <= leave_s1 && ctl_s1.emit;
			end
			if (leave_s1) begin
				win1_q <= win2_q;
				win2_q <= col_new;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < KSIZE; i++) begin
			view_d[i*KSIZE+0] = win1_q[i];
			view_d[i*KSIZE+1] = win2_q[i];
			view_d[i*KSIZE+2] = col_new[i];
		end
	end

	assign view_vld = vld_s2;
	assign view = view_s2;
	assign view_ctl = ctl_s2;

endmodule

// File: rtl/core/rgb3c_mac.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution: multiply-accumulate
// Weights the nine window pixels of each channel, sums them, rounds and
// clamps the result and holds it in the output register.
// ----------------------------------------------------------------------------
module rgb3c_mac #(
	parameter int COEF_BITS = rgb3c_pkg::COEF_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             vld,
	input  rgb3c_pkg::view_t                                 view,
	input  rgb3c_pkg::tap_ctl_t                              ctl,
	input  logic [rgb3c_pkg::KSIZE*COEF_BITS-1:0]            coef_top,
	input  logic [rgb3c_pkg::KSIZE*COEF_BITS-1:0]            coef_mid,
	input  logic [rgb3c_pkg::KSIZE*COEF_BITS-1:0]            coef_bot,
	output logic                                             rdy,
	output logic                                             m_tvalid,
	input  logic                                             m_tready,
	output logic [rgb3c_pkg::CHANNELS*rgb3c_pkg::PIX_BITS-1:0] m_tdata,
	output logic                                             m_tlast
);
	import rgb3c_pkg::*;

	localparam int PW = COEF_BITS + PIX_BITS + 1;
	localparam int SW = PW + $clog2(TAPS);
	localparam int RW = SW - COEF_FRAC;

	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] sum_t;

	logic [KSIZE*COEF_BITS-1:0]  coef_rows [KSIZE];
	logic signed [COEF_BITS-1:0] coef [TAPS];

	prod_t prod_d [CHANNELS][TAPS];
	prod_t prod_s3 [CHANNELS][TAPS];
	sum_t  sum_d [CHANNELS];
	sum_t  sum_s4 [CHANNELS];
	logic [SW-1:0] biased [CHANNELS];
	logic [RW-1:0] rnd [CHANNELS];
	logic [PIX_BITS-1:0] res_d [CHANNELS];

	logic vld_s3, vld_s4, last_s3, last_s4, out_vld_q, out_last_q;
	logic [CHANNELS*PIX_BITS-1:0] out_data_q;
	logic can_s3, can_s4, can_out;

	assign coef_rows[0] = coef_top;
	assign coef_rows[1] = coef_mid;
	assign coef_rows[2] = coef_bot;

	always_comb begin
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				coef[i*KSIZE+j] = coef_rows[i][j*COEF_BITS +: COEF_BITS];
			end
		end
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int k = 0; k < TAPS; k++) begin
				if (ctl.mask[k]) begin
					prod_d[ch][k] = PW'($signed({1'b0, view[k][ch*PIX_BITS +: PIX_BITS]}))
						* PW'(coef[k]);
				end else begin
					prod_d[ch][k] = '0;
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			sum_d[ch] = '0;
			for (int k = 0; k < TAPS; k++) begin
				sum_d[ch] = sum_d[ch] + SW'(prod_s3[ch][k]);
			end
		end
	end

	// Halves round away from zero; any negative sum ends at zero.
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			biased[ch] = sum_s4[ch] + SW'(1 << (COEF_FRAC - 1));
			rnd[ch] = biased[ch][SW-1:COEF_FRAC];
			if (sum_s4[ch][SW-1]) begin
				res_d[ch] = '0;
			end else if (rnd[ch] > RW'(PIX_MAX)) begin
				res_d[ch] = PIX_MAX;
			end else begin
				res_d[ch] = PIX_BITS'(rnd[ch]);
			end
		end
	end

	assign can_out = !out_vld_q || m_tready;
	assign can_s4 = !vld_s4 || can_out;
	assign can_s3 = !vld_s3 || can_s4;
	assign rdy = can_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (can_s3) begin
				vld_s3 <= vld;
			end
			if (can_s4) begin
				vld_s4 <= vld_s3;
			end
			if (can_out) begin
				out_vld_q <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_s3 && vld) begin
			prod_s3 <= prod_d;
			last_s3 <= ctl.last;
		end
		if (can_s4 && vld_s3) begin
			sum_s4 <= sum_d;
			last_s4 <= last_s3;
		end
		if (can_out && vld_s4) begin
			out_data_q <= {res_d[2], res_d[1], res_d[0]};
			out_last_q <= last_s4;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

endmodule

// File: rtl/core/rgb_3x3_convolution.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution
// Streaming 3x3 convolution of an RGB image in raster order, one pixel per
// item, with signed Q4.8 coefficients and rounded, clamped results.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  s_*      in         s_tvalid/s_tready    pixel in tdata, drain flag in tuser
//  m_*      out        m_tvalid/m_tready    filtered pixel in tdata, frame end in tlast
//  cfg_*    in         cfg_valid/cfg_ready  register index and write data
//
// One item is taken per cycle while the pipeline has room; the line-store read of
// each column is registered, then the window, the products, the sums and the
// rounded, clamped result, which leaves with its frame end.
// Reset clears the scan position, the window and the pipeline valids and loads
// the register defaults; the line stores are not cleared.
// A stalled output holds the pipeline stage by stage, and the input stays ready
// while an earlier stage still has room.
//
module rgb_3x3_convolution #(
	parameter int MAX_WIDTH = rgb3c_pkg::MAX_WIDTH_DEF,
	parameter int COEF_BITS = rgb3c_pkg::COEF_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// pix_red [7:0], pix_green [15:8], pix_blue [23:16]
	input  logic [23:0]                                   s_tdata,
	// drain [0]
	input  logic                                          s_tuser,
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// res_red [7:0], res_green [15:8], res_blue [23:16]
	output logic [23:0]                                   m_tdata,
	output logic                                          m_tlast,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [rgb3c_pkg::CFG_IDX_BITS-1:0]            cfg_index,
	input  logic [rgb3c_pkg::KSIZE*COEF_BITS-1:0]         cfg_data
);
	import rgb3c_pkg::*;

	localparam int CFW = KSIZE * COEF_BITS;
	localparam int AW = $clog2(MAX_WIDTH);
	localparam logic [CFW-1:0] MID_RESET = CFW'(1) << (COEF_BITS + COEF_FRAC);

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [CFW-1:0]         coef_top_q, coef_mid_q, coef_bot_q;

	logic     accept, tick, line_rdy, view_vld, mac_rdy;
	logic [AW-1:0] addr;
	pix_t     pix_tick;
	tap_ctl_t ctl_tick, view_ctl;
	view_t    view;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			coef_top_q <= '0;
			coef_mid_q <= MID_RESET;
			coef_bot_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_data[WIDTH_BITS-1:0];
				end
				REG_HEIGHT: begin
					height_q <= cfg_data[HEIGHT_BITS-1:0];
				end
				REG_COEF_TOP: begin
					coef_top_q <= cfg_data;
				end
				REG_COEF_MID: begin
					coef_mid_q <= cfg_data;
				end
				REG_COEF_BOT: begin
					coef_bot_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign s_tready = line_rdy;
	assign accept = s_tvalid && s_tready;

	rgb3c_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_width (width_q),
		.cfg_height(height_q),
		.accept    (accept),
		.drain     (s_tuser),
		.pix       (s_tdata),
		.tick      (tick),
		.addr      (addr),
		.pix_out   (pix_tick),
		.ctl       (ctl_tick)
	);

	rgb3c_line #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_vld(accept && tick),
		.addr    (addr),
		.pix     (pix_tick),
		.ctl     (ctl_tick),
		.rdy     (line_rdy),
		.view_vld(view_vld),
		.view    (view),
		.view_ctl(view_ctl),
		.view_rdy(mac_rdy)
	);

	rgb3c_mac #(
		.COEF_BITS(COEF_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (view_vld),
		.view    (view),
		.ctl     (view_ctl),
		.coef_top(coef_top_q),
		.coef_mid(coef_mid_q),
		.coef_bot(coef_bot_q),
		.rdy     (mac_rdy),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution testbench
// Streams raster-order RGB frames through the filter under a range of frame
// sizes and kernels. A behavioural model of the line stores and window works
// out each filtered pixel, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rgb3c_pkg::*;

	localparam int CFG_DATA_BITS = KSIZE * COEF_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;

	typedef enum int {KERN_MILD, KERN_WILD, KERN_EDGE, KERN_BOX} kernel_style_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] red;
		logic [PIX_BITS-1:0] green;
		logic [PIX_BITS-1:0] blue;
		logic                last;
	} result_t;

	class filter_scoreboard;
		pix_t prev_row [MAX_WIDTH_DEF];
		pix_t prev_row2 [MAX_WIDTH_DEF];
		pix_t win [KSIZE][KSIZE];
		int col;
		int row;
		logic [WIDTH_BITS-1:0] width;
		logic [HEIGHT_BITS-1:0] height;
		logic [CFG_DATA_BITS-1:0] coef [KSIZE];
		result_t expected_pixels [$];
		int mismatches;
		int results_seen;
		bit frame_over;

		function new();
			foreach (prev_row[i]) begin
				prev_row[i] = '0;
				prev_row2[i] = '0;
			end
			foreach (win[i, j]) win[i][j] = '0;
			col = 0;
			row = 0;
			width = WIDTH_RESET;
			height = HEIGHT_RESET;
			coef[0] = '0;
			coef[1] = CFG_DATA_BITS'(256) << COEF_BITS_DEF;
			coef[2] = '0;
			mismatches = 0;
			results_seen = 0;
			frame_over = 1'b0;
		endfunction

		function int eff_width();
			int w;
			w = width;
			if (w == 0) w = 1;
			if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
			return w;
		endfunction

		function int eff_height();
			int h;
			h = height;
			if (h == 0) h = 1;
			return h;
		endfunction

		function bit input_complete();
			return row >= eff_height();
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void load_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				REG_WIDTH: width = value[WIDTH_BITS-1:0];
				REG_HEIGHT: height = value[HEIGHT_BITS-1:0];
				REG_COEF_TOP: coef[0] = value;
				REG_COEF_MID: coef[1] = value;
				REG_COEF_BOT: coef[2] = value;
				default: ;
			endcase
		endfunction

		function void shift_in(col_t fresh);
			for (int i = 0; i < KSIZE; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
				win[i][2] = fresh[i];
			end
		endfunction

		function logic [PIX_BITS-1:0] round_clamp(int s);
			int r;
			if (s < 0) return '0;
			r = (s + (1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
			return (r > int'(PIX_MAX)) ? PIX_MAX : r[PIX_BITS-1:0];
		endfunction

		function void take_item(pix_t px, logic drain);
			int w, h, c, orow, ocol, rr, cc;
			int sum [CHANNELS];
			col_t fresh;
			pix_t view [KSIZE][KSIZE];
			logic signed [COEF_BITS_DEF-1:0] k;
			bit complete, emit, last;
			result_t res;
			w = eff_width();
			h = eff_height();
			complete = row >= h;
			if (drain && !complete) return;
			c = col;
			fresh[0] = '0;
			fresh[1] = '0;
			fresh[2] = (!drain && !complete) ? px : '0;
			if (c < MAX_WIDTH_DEF) begin
				fresh[0] = prev_row2[c];
				fresh[1] = prev_row[c];
				prev_row2[c] = fresh[1];
				prev_row[c] = fresh[2];
			end
			emit = (row >= 2) || (row == 1 && c >= 1);
			last = 1'b0;
			if (emit) begin
				// At the start of a row the window still holds the end of the row above.
				if (c == 0) begin
					orow = row - 2;
					ocol = w - 1;
					for (int i = 0; i < KSIZE; i++) begin
						view[i][0] = win[i][1];
						view[i][1] = win[i][2];
						view[i][2] = '0;
					end
					shift_in(fresh);
				end else begin
					orow = row - 1;
					ocol = c - 1;
					shift_in(fresh);
					view = win;
				end
				for (int ch = 0; ch < CHANNELS; ch++) sum[ch] = 0;
				for (int i = 0; i < KSIZE; i++) begin
					rr = orow - 1 + i;
					if (rr < 0 || rr >= h) continue;
					for (int j = 0; j < KSIZE; j++) begin
						cc = ocol - 1 + j;
						if (cc < 0 || cc >= w) continue;
						k = coef[i][j*COEF_BITS_DEF +: COEF_BITS_DEF];
						for (int ch = 0; ch < CHANNELS; ch++)
							sum[ch] += int'(view[i][j][PIX_BITS*ch +: PIX_BITS]) * int'(k);
					end
				end
				last = (orow > h - 1) || (orow == h - 1 && ocol >= w - 1);
				res.red = round_clamp(sum[0]);
				res.green = round_clamp(sum[1]);
				res.blue = round_clamp(sum[2]);
				res.last = last;
				expected_pixels.push_back(res);
			end else begin
				shift_in(fresh);
			end
			if (c + 1 >= w) begin
				col = 0;
				row++;
			end else begin
				col = c + 1;
			end
			if (last) begin
				col = 0;
				row = 0;
				frame_over = 1'b1;
			end
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40) $display("%0t ns: result %0d: %s", $time, results_seen, msg);
		endtask

		task check_result(pix_t data, logic tlast);
			result_t want;
			results_seen++;
			if (expected_pixels.size() == 0) begin
				report("result arrived with none outstanding");
				return;
			end
			want = expected_pixels.pop_front();
			if (data[7:0] !== want.red)
				report($sformatf("red %0d, expected %0d", data[7:0], want.red));
			if (data[15:8] !== want.green)
				report($sformatf("green %0d, expected %0d", data[15:8], want.green));
			if (data[23:16] !== want.blue)
				report($sformatf("blue %0d, expected %0d", data[23:16], want.blue));
			if (tlast !== want.last)
				report($sformatf("frame end %0b, expected %0b", tlast, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	filter_scoreboard sb;
	int items_sent = 0;
	int send_idle_pct = 10;
	int recv_idle_pct = 5;
	int stall_left = 0;
	int starved_cycles = 0;
	bit no_idling = 1'b0;

	rgb_3x3_convolution dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) sb.load_reg(cfg_index, cfg_data);
		if (s_tvalid && s_tready) sb.take_item(s_tdata, s_tuser);
		if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
		if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			starved_cycles = 0;
		else
			starved_cycles++;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!no_idling && $urandom_range(0, 99) < recv_idle_pct) begin
			stall_left = $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		wait (starved_cycles >= WATCHDOG_LIMIT);
		$display("rgb_3x3_convolution test failed");
		$finish;
	end

	function automatic kernel_style_t pick_style();
		case ($urandom_range(0, 9))
			7, 8: return KERN_WILD;
			9: return ($urandom_range(0, 1) != 0) ? KERN_EDGE : KERN_BOX;
			default: return KERN_MILD;
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] coef_row(input kernel_style_t style);
		logic [CFG_DATA_BITS-1:0] packed_row;
		logic [COEF_BITS_DEF-1:0] k;
		int j;
		for (j = 0; j < KSIZE; j++) begin
			case (style)
				KERN_WILD: k = COEF_BITS_DEF'($urandom);
				KERN_BOX: k = COEF_BITS_DEF'(28);
				KERN_EDGE: begin
					case ($urandom_range(0, 3))
						0: k = 13'h1000;
						1: k = 13'h0FFF;
						2: k = 13'h1FFF;
						default: k = '0;
					endcase
				end
				default: k = COEF_BITS_DEF'($urandom_range(0, 120) - 40);
			endcase
			packed_row[j*COEF_BITS_DEF +: COEF_BITS_DEF] = k;
		end
		return packed_row;
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Bit 0 of which selects the width, bit 1 the height, bits 2 to 4 the kernel rows.
	task automatic configure(input bit [4:0] which, input int w, input int h,
			input logic [CFG_DATA_BITS-1:0] top, input logic [CFG_DATA_BITS-1:0] mid,
			input logic [CFG_DATA_BITS-1:0] bot);
		if (which[0]) cfg_write(REG_WIDTH, CFG_DATA_BITS'(w));
		if (which[1]) cfg_write(REG_HEIGHT, CFG_DATA_BITS'(h));
		if (which[2]) cfg_write(REG_COEF_TOP, top);
		if (which[3]) cfg_write(REG_COEF_MID, mid);
		if (which[4]) cfg_write(REG_COEF_BOT, bot);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input pix_t px, input logic drain);
		if (!no_idling && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tuser <= drain;
		items_sent++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Sends one frame, or stops once stop_at pixels have entered the frame.
	task automatic send_frame(input int stop_at);
		int pix_ticks;
		pix_ticks = 0;
		sb.frame_over = 1'b0;
		while (!sb.frame_over && pix_ticks != stop_at) begin
			if (sb.input_complete()) begin
				send_item(pix_t'($urandom), $urandom_range(0, 3) != 0);
			end else if ($urandom_range(0, 9) == 0) begin
				send_item(pix_t'($urandom), 1'b1);
			end else begin
				send_item(pix_t'($urandom), 1'b0);
				pix_ticks++;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// The sender holds off until every result is out and the pipeline has emptied.
	task automatic settle();
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int budget, phase, w, h, stop_at;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		configure(5'b11111, 3, 2, {13'd128, 13'h0FFF, 13'h1000},
			{13'h1FFF, 13'd128, 13'd256}, {13'h1000, 13'h0FFF, 13'd1});
		send_item(24'h000000, 1'b0);
		send_item(24'hFFFFFF, 1'b0);
		send_item(24'h01FE80, 1'b0);
		send_item(24'h123456, 1'b1);
		send_item(24'h7F80FF, 1'b0);
		send_item(24'hAA5533, 1'b0);
		send_item(24'h55AACC, 1'b0);
		send_item(24'hFFFFFF, 1'b1);
		send_item(24'hC3C3C3, 1'b0);
		send_item(24'h000000, 1'b1);
		send_item(24'h0F0F0F, 1'b1);
		s_tvalid <= 1'b0;
		settle();

		// A zero width and height act as one; a half coefficient exercises rounding.
		configure(5'b11111, 0, 0, '0, {13'd0, 13'd128, 13'd0}, '0);
		send_item(24'h8101FF, 1'b0);
		send_item(24'hFFFFFF, 1'b1);
		send_item(24'h000000, 1'b1);
		s_tvalid <= 1'b0;
		settle();

		budget = 550;
		phase = 0;
		while (items_sent < budget) begin
			phase++;
			if (items_sent >= budget - 100) no_idling = 1'b1;
			send_idle_pct = no_idling ? 0 : 5 * $urandom_range(0, 5);
			recv_idle_pct = no_idling ? 0 : 4 * $urandom_range(0, 4);
			if (phase == 4) begin
				// An oversized width is clamped; a narrower width then closes the frame early.
				w = $urandom_range(2, 8);
				configure(5'b11111, 2047, 1, coef_row(KERN_MILD), coef_row(KERN_MILD),
					coef_row(KERN_MILD));
				send_frame($urandom_range(w + 1, 24));
				settle();
				configure(5'b00001, w, 1, '0, '0, '0);
				send_frame(-1);
			end else if (phase == 6) begin
				w = $urandom_range(2, 8);
				h = $urandom_range(3, 5);
				stop_at = w + $urandom_range(0, w * (h - 1) - 1);
				configure(5'b11111, w, h, coef_row(pick_style()), coef_row(pick_style()),
					coef_row(pick_style()));
				send_frame(stop_at);
				settle();
				configure(5'b11110, 0, $urandom_range(1, 6), coef_row(pick_style()),
					coef_row(pick_style()), coef_row(pick_style()));
				send_frame(-1);
			end else begin
				case ($urandom_range(0, 9))
					0: w = 0;
					7, 8: w = $urandom_range(9, 24);
					9: w = 1;
					default: w = $urandom_range(1, 8);
				endcase
				case ($urandom_range(0, 9))
					0: h = 0;
					8, 9: h = (w > 8) ? $urandom_range(1, 3) : $urandom_range(5, 8);
					default: h = $urandom_range(1, 4);
				endcase
				configure({3'($urandom_range(0, 7)), 2'b11}, w, h, coef_row(pick_style()),
					coef_row(pick_style()), coef_row(pick_style()));
				send_frame(-1);
			end
			settle();
		end

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("rgb_3x3_convolution test passed");
		else
			$display("rgb_3x3_convolution test failed");
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/rgb3c_pkg.sv
rtl/core/rgb3c_ctrl.sv
rtl/core/rgb3c_line.sv
rtl/core/rgb3c_mac.sv
rtl/core/rgb_3x3_convolution.sv
tb/tb_top.sv
